// ===== hw/rtl/srr_pkg.sv =====
// Shared types and constants for the selective-repeat receiver.
package srr_pkg;

  localparam int SEQ_COUNT_DEF    = 20;
  localparam int WINDOW_DEF       = 5;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int HDR_W  = 8;
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;

  localparam logic [HDR_W-1:0] HDR_START  = 8'd205;
  localparam logic [HDR_W-1:0] HDR_FINISH = 8'd204;

  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READY   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_FINISH = 2'd1,
    OP_DATA   = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [HDR_W-1:0]  seq;
    logic [WORD_W-1:0] payload;
  } cmd_t;

endpackage

// ===== hw/rtl/srr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/srr_front.sv =====
// Front end: accept packets, classify headers, drop headers with no meaning.
module srr_front #(
  parameter int SEQ_COUNT = srr_pkg::SEQ_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [srr_pkg::HDR_W-1:0] header,
  input  logic [srr_pkg::WORD_W-1:0] payload,
  output logic                      cmd_valid,
  input  logic                      cmd_ready,
  output srr_pkg::cmd_t             cmd
);
  import srr_pkg::*;

  localparam logic [HDR_W-1:0] SEQ_MAX = HDR_W'(SEQ_COUNT);

  logic  keep;
  op_t   op_class;
  logic  valid;

  always_comb begin
    keep     = 1'b1;
    op_class = OP_DATA;
    if (header == HDR_START) begin
      op_class = OP_START;
    end else if (header == HDR_FINISH) begin
      op_class = OP_FINISH;
    end else if (header == '0 || header > SEQ_MAX) begin
      keep = 1'b0;
    end
  end

  assign in_ready  = !valid || cmd_ready;
  assign cmd_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      cmd.op      <= op_class;
      cmd.seq     <= header;
      cmd.payload <= payload;
    end
  end

endmodule

// ===== hw/rtl/srr_queue.sv =====
// Short command queue between the front end and the back end.
module srr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  srr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output srr_pkg::cmd_t pop_cmd
);
  import srr_pkg::*;

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entry[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= bump(wptr);
      end
      if (pop) begin
        rptr <= bump(rptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/srr_back.sv =====
// Back end: receive state, held payload store, drain sequencer, output register.
module srr_back #(
  parameter int SEQ_COUNT    = srr_pkg::SEQ_COUNT_DEF,
  parameter int WINDOW       = srr_pkg::WINDOW_DEF,
  parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  srr_pkg::cmd_t               cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [srr_pkg::KIND_W-1:0]  out_kind,
  output logic [srr_pkg::WORD_W-1:0]  out_value,
  output logic                        out_last
);
  import srr_pkg::*;

  localparam int STORE_W = (PAYLOAD_BITS < WORD_W) ? PAYLOAD_BITS : WORD_W;
  localparam int SEQ_W   = $clog2(SEQ_COUNT + 1);
  localparam int ADDR_W  = $clog2(SEQ_COUNT);
  localparam int CNT_W   = $clog2(WINDOW + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_ACK   = 2'd3;

  logic [1:0]           state;
  logic                 receiving;
  logic [SEQ_W-1:0]     expected;
  logic [SEQ_COUNT-1:0] marks;
  logic [CNT_W-1:0]     drained;
  logic [SEQ_W-1:0]     ack_seq;

  logic                 out_free;
  logic                 out_load;
  logic                 take;
  logic [SEQ_W-1:0]     seq;
  logic [ADDR_W-1:0]    cmd_idx;
  logic [ADDR_W-1:0]    exp_idx;
  logic [STORE_W-1:0]   pay;
  logic [SEQ_W:0]       diff;
  logic [SEQ_W:0]       span;
  logic                 in_order;
  logic                 ahead;
  logic                 drain_go;
  logic                 ram_we;
  logic [STORE_W-1:0]   ram_rdata;

  function automatic logic [SEQ_W-1:0] advance(input logic [SEQ_W-1:0] s);
    return (s >= SEQ_W'(SEQ_COUNT)) ? SEQ_W'(1) : s + 1'b1;
  endfunction

  assign out_free  = !out_valid || out_ready;
  assign take      = (state == ST_IDLE) && cmd_valid && out_free;
  assign cmd_ready = (state == ST_IDLE) && out_free;
  assign out_load  = (take && (cmd.op == OP_START || receiving)) ||
                     ((state == ST_READ || state == ST_ACK) && out_free);

  assign seq     = cmd.seq[SEQ_W-1:0];
  assign cmd_idx = ADDR_W'(seq - 1'b1);
  assign exp_idx = ADDR_W'(expected - 1'b1);
  assign pay     = cmd.payload[STORE_W-1:0];

  assign diff     = {1'b0, seq} - {1'b0, expected};
  assign span     = diff[SEQ_W] ? diff + (SEQ_W + 1)'(SEQ_COUNT) : diff;
  assign in_order = span == '0;
  assign ahead    = !in_order && (32'(span) < 32'(WINDOW));

  assign drain_go = marks[exp_idx] && (drained != CNT_W'(WINDOW));
  assign ram_we   = take && receiving && cmd.op == OP_DATA && ahead;

  srr_ram #(
    .WIDTH (STORE_W),
    .DEPTH (SEQ_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd_idx),
    .wdata (pay),
    .re    (state == ST_CHECK && drain_go),
    .raddr (exp_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      receiving <= 1'b0;
      expected  <= SEQ_W'(1);
      marks     <= '0;
      drained   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (cmd.op == OP_START) begin
              receiving <= 1'b1;
              expected  <= SEQ_W'(1);
              marks     <= '0;
              out_valid <= 1'b1;
              out_kind  <= KIND_READY;
              out_value <= '0;
              out_last  <= 1'b1;
            end else if (receiving) begin
              out_valid <= 1'b1;
              if (cmd.op == OP_FINISH) begin
                out_kind  <= KIND_FINISH;
                out_value <= '0;
                out_last  <= 1'b1;
              end else if (in_order) begin
                out_kind  <= KIND_DELIVER;
                out_value <= WORD_W'(pay);
                out_last  <= 1'b0;
                expected  <= advance(expected);
                drained   <= '0;
                ack_seq   <= seq;
                state     <= ST_CHECK;
              end else begin
                if (ahead) begin
                  marks[cmd_idx] <= 1'b1;
                end
                out_kind  <= KIND_ACK;
                out_value <= WORD_W'(seq);
                out_last  <= 1'b1;
              end
            end
          end
        end
        ST_CHECK: begin
          if (drain_go) begin
            marks[exp_idx] <= 1'b0;
            state          <= ST_READ;
          end else begin
            state <= ST_ACK;
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_DELIVER;
            out_value <= WORD_W'(ram_rdata);
            out_last  <= 1'b0;
            expected  <= advance(expected);
            drained   <= drained + 1'b1;
            state     <= ST_CHECK;
          end
        end
        ST_ACK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_ACK;
            out_value <= WORD_W'(ack_seq);
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/selective_repeat_receiver.sv =====
// Top level of the selective-repeat receiver.
//
// The slave stream takes one arriving packet per transaction: tdata carries
// the header byte and the payload word. The master stream gives the results
// of each packet, the final one marked by tlast; tuser gives the result kind
// (acknowledgement, in-order delivery, ready reply, finished notice).
// Header 205 opens a transfer, 204 reports finish, 1..SEQ_COUNT are data.
// Packets with other headers are dropped in the front end and never reach the
// back end.
// The back end sequencer handles a start, finish, ack or hold in its idle
// state alone; an in-order packet then runs a mark check and a store read
// per drained held payload, at most WINDOW of them, then a last mark check
// and its ack. A two-entry queue and the front register absorb input while
// the back end drains.
// Reset clears the receive state and all held marks; the payload store
// needs no clearing pass. When the master side stalls, the output register
// holds and the back end waits; the front end and queue keep accepting until
// they fill.
module selective_repeat_receiver #(
  parameter int SEQ_COUNT    = srr_pkg::SEQ_COUNT_DEF,
  parameter int WINDOW       = srr_pkg::WINDOW_DEF,
  parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // header [7:0], payload [39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value [31:0]
  output logic [1:0]  m_tuser,   // kind [1:0]
  output logic        m_tlast
);
  import srr_pkg::*;

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  srr_front #(
    .SEQ_COUNT (SEQ_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .header    (s_tdata[7:0]),
    .payload   (s_tdata[39:8]),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  srr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  srr_back #(
    .SEQ_COUNT    (SEQ_COUNT),
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_value (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ===== tb/sv/tb_selective_repeat_receiver.sv =====
// Testbench for selective_repeat_receiver: stream stimulus, result prediction and checking.
`timescale 1ns / 1ps

typedef struct {
  logic [1:0]  kind;
  logic [31:0] value;
  logic        last;
} arq_result_t;

class arq_ledger;
  bit          receiving;
  int          next_seq;
  bit          held_mark[srr_pkg::SEQ_COUNT_DEF];
  logic [31:0] held_word[srr_pkg::SEQ_COUNT_DEF];
  arq_result_t awaited[$];
  int          errors;

  function new();
    receiving = 0;
    next_seq  = 1;
    errors    = 0;
    foreach (held_mark[i]) held_mark[i] = 0;
  endfunction

  function void push(logic [1:0] kind, logic [31:0] value);
    arq_result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = 0;
    awaited.push_back(r);
  endfunction

  function void step_seq();
    next_seq = (next_seq >= srr_pkg::SEQ_COUNT_DEF) ? 1 : next_seq + 1;
  endfunction

  function int note_packet(logic [7:0] hdr, logic [31:0] word);
    int n0;
    int span;
    int seq;
    n0  = awaited.size();
    seq = hdr;
    if (hdr == srr_pkg::HDR_START) begin
      receiving = 1;
      next_seq  = 1;
      foreach (held_mark[i]) held_mark[i] = 0;
      push(srr_pkg::KIND_READY, 32'd0);
    end else if (receiving && hdr == srr_pkg::HDR_FINISH) begin
      push(srr_pkg::KIND_FINISH, 32'd0);
    end else if (receiving && seq >= 1 && seq <= srr_pkg::SEQ_COUNT_DEF) begin
      span = (seq + srr_pkg::SEQ_COUNT_DEF - next_seq) % srr_pkg::SEQ_COUNT_DEF;
      if (span == 0) begin
        push(srr_pkg::KIND_DELIVER, word);
        step_seq();
        for (int k = 0; k < srr_pkg::WINDOW_DEF; k++) begin
          if (!held_mark[next_seq-1]) break;
          held_mark[next_seq-1] = 0;
          push(srr_pkg::KIND_DELIVER, held_word[next_seq-1]);
          step_seq();
        end
      end else if (span < srr_pkg::WINDOW_DEF) begin
        held_word[seq-1] = word;
        held_mark[seq-1] = 1;
      end
      push(srr_pkg::KIND_ACK, {24'd0, hdr});
    end
    if (awaited.size() > n0) awaited[awaited.size()-1].last = 1;
    return awaited.size() - n0;
  endfunction

  function void check_result(logic [1:0] kind, logic [31:0] value, logic last);
    arq_result_t e;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result kind %0d value %h last %b", $time, kind, value, last);
      errors++;
      return;
    end
    e = awaited.pop_front();
    if (kind !== e.kind || value !== e.value || last !== e.last) begin
      $display("%0t: mismatch expected kind %0d value %h last %b, actual kind %0d value %h last %b",
               $time, e.kind, e.value, e.last, kind, value, last);
      errors++;
    end
  endfunction
endclass

module tb_selective_repeat_receiver;
  import srr_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  arq_ledger   ledger;
  int          burst_left;
  int          live_packets;
  logic [15:0] stall_pat;
  int          stall_age;

  selective_repeat_receiver dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    m_tready  = 0;
    stall_pat = '1;
    stall_age = 0;
    forever begin
      @(negedge clk);
      if (stall_age == 0) begin
        stall_age = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = 16'hAAAA;
          default: stall_pat = 16'($urandom);
        endcase
      end
      stall_age--;
      m_tready  = stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ledger.check_result(m_tuser, m_tdata, m_tlast);
  end

  task automatic send_packet(logic [7:0] hdr, logic [31:0] word);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid = 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid = 1;
    s_tdata  = {word, hdr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (ledger.note_packet(hdr, word) > 0) live_packets++;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid = 0;
    while (ledger.awaited.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic send_window();
    int k;
    int j;
    int tmp;
    int seqs[WINDOW_DEF];
    k = $urandom_range(1, WINDOW_DEF);
    for (int i = 0; i < k; i++)
      seqs[i] = ((ledger.next_seq - 1 + i) % SEQ_COUNT_DEF) + 1;
    for (int i = k - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = seqs[i];
      seqs[i] = seqs[j];
      seqs[j] = tmp;
    end
    for (int i = 0; i < k; i++) begin
      send_packet(seqs[i][7:0], $urandom);
      if ($urandom_range(0, 7) == 0) send_packet(seqs[i][7:0], $urandom);
    end
  endtask

  initial begin
    int  r;
    bit  paused;
    ledger       = new();
    rst          = 1;
    s_tvalid     = 0;
    s_tdata      = '0;
    burst_left   = 0;
    live_packets = 0;
    paused       = 0;
    repeat (9) @(negedge clk);
    rst = 0;

    send_packet(8'd3, 32'h0000_0011);
    send_packet(HDR_FINISH, 32'd0);
    send_packet(HDR_START, 32'd0);
    send_packet(8'd0, 32'h1234_0000);
    send_packet(8'd255, 32'hFFFF_FFFF);
    send_packet(8'd21, 32'h5555_5555);
    send_packet(8'd200, 32'hAAAA_AAAA);
    send_packet(8'd1, 32'h0000_0000);
    send_packet(8'd3, 32'hFFFF_FFFF);
    send_packet(8'd3, 32'hA5A5_A5A5);
    send_packet(8'd2, 32'h1234_5678);
    for (int s = 5; s <= 8; s++) send_packet(s[7:0], $urandom);
    send_packet(8'd9, 32'hDEAD_BEEF);
    send_packet(8'd1, 32'h0BAD_F00D);
    send_packet(8'd4, 32'h8000_0001);
    send_packet(HDR_FINISH, 32'hFFFF_FFFF);
    send_packet(8'd11, 32'h7FFF_FFFE);
    send_packet(HDR_START, 32'd0);
    send_packet(8'd20, 32'hC3C3_C3C3);
    send_packet(8'd1, 32'h3C3C_3C3C);

    live_packets = 0;
    while (live_packets < 110) begin
      r = $urandom_range(0, 19);
      case (r)
        0: send_packet(8'($urandom_range(0, 255)), $urandom);
        1: send_packet(HDR_START, $urandom);
        2: send_packet(HDR_FINISH, $urandom);
        3: send_packet(8'($urandom_range(1, SEQ_COUNT_DEF)), $urandom);
        default: send_window();
      endcase
      if (!paused && live_packets >= 55) begin
        wait_drained();
        paused = 1;
      end
    end

    wait_drained();
    if (ledger.awaited.size() != 0)
      $display("%0t: %0d results never arrived", $time, ledger.awaited.size());
    if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
